/* rtl/sti_pkg.sv */
// Shared types and constants for the segment/triangle intersection core.
package sti_pkg;

  // Width of a cross-product component. Components wrap at this width.
  localparam int unsigned CROSS_W  = 64;
  localparam int unsigned HALF_W   = 32;
  localparam int unsigned PART_W   = 66;
  localparam int unsigned DOTP_W   = 128;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERTEX_A     = 3'd0,
    REG_VERTEX_B     = 3'd1,
    REG_VERTEX_C     = 3'd2,
    REG_PLANE_NORMAL = 3'd3,
    REG_PLANE_EPS    = 3'd4
  } reg_idx_e;

  // Per-request decision flags that travel down the pipeline.
  typedef struct packed {
    logic par;   // shift parallel to the plane
    logic inpl;  // start lies in the plane
    logic go;    // coefficient in [0,1], run containment test
    logic eq;    // coefficient is exactly one
  } flags_t;

endpackage

/* rtl/segment_triangle_intersect_core.sv */
// Segment against triangle intersection core, fully pipelined.
//
//   channel   signals                                   direction
//   --------  ----------------------------------------  ---------
//   input     in_valid_i/in_ready_o, start_*, shift_*   in
//   result    out_valid_o/out_ready_i, hit, hit_*       out
//   config    cfg_we_i, cfg_idx_i, cfg_data_i           in
//
// One request per cycle while the output skid register is empty; a
// restoring divider yields one coefficient bit per stage.
// Reset clears the valid bits, the output skid register and the triangle
// registers (plane_eps resets to one). A stalled result moves into a skid
// register; the pipeline freezes only while that register is full.
module segment_triangle_intersect_core #(
  parameter int unsigned COORD_BITS = 20,
  parameter int unsigned FRAC_BITS  = 20
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sti_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [3*COORD_BITS-1:0]              cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [COORD_BITS-1:0]         start_x_i,
  input  logic signed [COORD_BITS-1:0]         start_y_i,
  input  logic signed [COORD_BITS-1:0]         start_z_i,
  input  logic signed [COORD_BITS:0]           shift_x_i,
  input  logic signed [COORD_BITS:0]           shift_y_i,
  input  logic signed [COORD_BITS:0]           shift_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 hit_o,
  output logic signed [COORD_BITS+FRAC_BITS:0] hit_x_o,
  output logic signed [COORD_BITS+FRAC_BITS:0] hit_y_o,
  output logic signed [COORD_BITS+FRAC_BITS:0] hit_z_o
);

  localparam int unsigned C      = COORD_BITS;
  localparam int unsigned F      = FRAC_BITS;
  localparam int unsigned SH_W   = C + 1;
  localparam int unsigned OUT_W  = C + F + 1;
  localparam int unsigned PR_W   = 2 * C + 1;
  localparam int unsigned DOT_W  = 2 * C + 3;
  localparam int unsigned EPS_W  = 2 * C + 3;
  localparam int unsigned CFG_W  = 3 * C;
  localparam int unsigned CO_W   = F + 1;
  localparam int unsigned CS_W   = F + C + 3;
  localparam int unsigned SUM_W  = F + C + 4;
  localparam int unsigned W_W    = OUT_W + 1;
  localparam int unsigned E_W    = C + 1;
  localparam int unsigned EW_W   = E_W + W_W;
  localparam int unsigned CR_W   = sti_pkg::CROSS_W;
  localparam int unsigned HW     = sti_pkg::HALF_W;
  localparam int unsigned PP_W   = sti_pkg::PART_W;
  localparam int unsigned DP_W   = sti_pkg::DOTP_W;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] va_q, vb_q, vc_q, nrm_q;
  logic [EPS_W-1:0] eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q  <= '0;
      vb_q  <= '0;
      vc_q  <= '0;
      nrm_q <= '0;
      eps_q <= EPS_W'(1);
    end else if (cfg_we_i) begin
      unique case (sti_pkg::reg_idx_e'(cfg_idx_i))
        sti_pkg::REG_VERTEX_A:     va_q  <= cfg_data_i;
        sti_pkg::REG_VERTEX_B:     vb_q  <= cfg_data_i;
        sti_pkg::REG_VERTEX_C:     vc_q  <= cfg_data_i;
        sti_pkg::REG_PLANE_NORMAL: nrm_q <= cfg_data_i;
        sti_pkg::REG_PLANE_EPS:    eps_q <= cfg_data_i[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [C-1:0]   vtx [3][3];
  logic signed [C-1:0]   nrm [3];
  logic signed [E_W-1:0] edg [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vtx[0][i] = va_q[i*C +: C];
      vtx[1][i] = vb_q[i*C +: C];
      vtx[2][i] = vc_q[i*C +: C];
      nrm[i]    = nrm_q[i*C +: C];
    end
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        edg[k][i] = E_W'(vtx[(k+1)%3][i]) - E_W'(vtx[k][i]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Flow control: global advance, skid register at the output
  // ---------------------------------------------------------------------
  logic skid_q;
  logic adv;

  assign adv        = !skid_q;
  assign in_ready_o = adv;

  logic signed [C-1:0]    s_in  [3];
  logic signed [SH_W-1:0] sh_in [3];

  always_comb begin
    s_in[0]  = start_x_i;
    s_in[1]  = start_y_i;
    s_in[2]  = start_z_i;
    sh_in[0] = shift_x_i;
    sh_in[1] = shift_y_i;
    sh_in[2] = shift_z_i;
  end

  // ---------------------------------------------------------------------
  // Stage 0: per-axis products with the normal
  // ---------------------------------------------------------------------
  logic                   v0_q;
  logic signed [PR_W-1:0] pd0_q [3];
  logic signed [PR_W-1:0] ps0_q [3];
  logic signed [C-1:0]    s0_q  [3];
  logic signed [SH_W-1:0] sh0_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pd0_q[i] <= (PR_W'(vtx[0][i]) - PR_W'(s_in[i])) * PR_W'(nrm[i]);
        ps0_q[i] <= PR_W'(sh_in[i]) * PR_W'(nrm[i]);
        s0_q[i]  <= s_in[i];
        sh0_q[i] <= sh_in[i];
      end
    end
  end

  // Stage 1: numerator and denominator sums
  logic                    v1_q;
  logic signed [DOT_W-1:0] p1_q, p2_q;
  logic signed [C-1:0]     s1_q  [3];
  logic signed [SH_W-1:0]  sh1_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q <= DOT_W'(pd0_q[0]) + DOT_W'(pd0_q[1]) + DOT_W'(pd0_q[2]);
      p2_q <= DOT_W'(ps0_q[0]) + DOT_W'(ps0_q[1]) + DOT_W'(ps0_q[2]);
      s1_q  <= s0_q;
      sh1_q <= sh0_q;
    end
  end

  // Stage 2: magnitudes and case decision
  logic [DOT_W-1:0] a1, a2;
  sti_pkg::flags_t  fl_d;

  always_comb begin
    a1 = p1_q[DOT_W-1] ? DOT_W'(-p1_q) : DOT_W'(p1_q);
    a2 = p2_q[DOT_W-1] ? DOT_W'(-p2_q) : DOT_W'(p2_q);
    fl_d.par  = a2 < eps_q;
    fl_d.inpl = a1 < eps_q;
    fl_d.eq   = a1 == a2;
    fl_d.go   = !fl_d.par && (a2 != '0) &&
                ((p1_q == '0) || ((p1_q[DOT_W-1] == p2_q[DOT_W-1]) && (a1 <= a2)));
  end

  logic                   v2_q;
  logic [DOT_W-1:0]       a1_2_q, a2_2_q;
  sti_pkg::flags_t        fl2_q;
  logic signed [C-1:0]    s2_q  [3];
  logic signed [SH_W-1:0] sh2_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a1_2_q <= a1;
      a2_2_q <= a2;
      fl2_q  <= fl_d;
      s2_q   <= s1_q;
      sh2_q  <= sh1_q;
    end
  end

  // ---------------------------------------------------------------------
  // Divider: one quotient bit per stage
  // ---------------------------------------------------------------------
  logic [F-1:0]           vd_q;
  logic [DOT_W-1:0]       rem_w [F+1];
  logic [F-1:0]           quo_w [F+1];
  logic [DOT_W-1:0]       den_w [F+1];
  sti_pkg::flags_t        fld_q [F];
  logic signed [C-1:0]    sd_q  [F][3];
  logic signed [SH_W-1:0] shd_q [F][3];

  assign rem_w[0] = a1_2_q;
  assign quo_w[0] = '0;
  assign den_w[0] = a2_2_q;

  for (genvar j = 0; j < F; j++) begin : g_div
    sti_div_step #(
      .REM_W (DOT_W),
      .QUO_W (F)
    ) u_step (
      .clk_i (clk_i),
      .en_i  (adv),
      .rem_i (rem_w[j]),
      .quo_i (quo_w[j]),
      .den_i (den_w[j]),
      .rem_o (rem_w[j+1]),
      .quo_o (quo_w[j+1]),
      .den_o (den_w[j+1])
    );

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (j == 0) begin
          fld_q[j] <= fl2_q;
          sd_q[j]  <= s2_q;
          shd_q[j] <= sh2_q;
        end else begin
          fld_q[j] <= fld_q[j-1];
          sd_q[j]  <= sd_q[j-1];
          shd_q[j] <= shd_q[j-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage C: coefficient times shift
  // ---------------------------------------------------------------------
  logic [CO_W-1:0] coef;

  assign coef = fld_q[F-1].eq ? (CO_W'(1) << F) : {1'b0, quo_w[F]};

  logic                   vc_q2;
  logic signed [CS_W-1:0] csc_q [3];
  logic signed [C-1:0]    sc_q  [3];
  sti_pkg::flags_t        flc_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        csc_q[i] <= CS_W'($signed({1'b0, coef})) * CS_W'(shd_q[F-1][i]);
      end
      sc_q  <= sd_q[F-1];
      flc_q <= fld_q[F-1];
    end
  end

  // Stage P: point, saturated to the output range
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  logic signed [SUM_W-1:0]  psum [3];
  logic signed [OUT_W-1:0]  pnt_d [3];
  logic                     ovf;

  always_comb begin
    ovf = 1'b0;
    for (int i = 0; i < 3; i++) begin
      psum[i] = (SUM_W'(sc_q[i]) <<< F) + SUM_W'(csc_q[i]);
      ovf = (psum[i][SUM_W-1:OUT_W-1] != '0) && (psum[i][SUM_W-1:OUT_W-1] != '1);
      if (flc_q.par) begin
        pnt_d[i] = OUT_W'(sc_q[i]) <<< F;
      end else if (ovf) begin
        pnt_d[i] = psum[i][SUM_W-1] ? OUT_MIN : OUT_MAX;
      end else begin
        pnt_d[i] = psum[i][OUT_W-1:0];
      end
    end
  end

  logic                    vp_q;
  logic signed [OUT_W-1:0] pp_q [3];
  sti_pkg::flags_t         flp_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pp_q  <= pnt_d;
      flp_q <= flc_q;
    end
  end

  // Stage E: edge times offset products for the three cross products
  logic signed [W_W-1:0] wv [3][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        wv[k][i] = W_W'(pp_q[i]) - (W_W'(vtx[(k+1)%3][i]) <<< F);
      end
    end
  end

  logic                   ve_q;
  logic signed [EW_W-1:0] m1_q [3][3];
  logic signed [EW_W-1:0] m2_q [3][3];
  logic signed [OUT_W-1:0] pe_q [3];
  sti_pkg::flags_t        fle_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          m1_q[k][i] <= EW_W'(edg[k][(i+1)%3]) * EW_W'(wv[k][(i+2)%3]);
          m2_q[k][i] <= EW_W'(edg[k][(i+2)%3]) * EW_W'(wv[k][(i+1)%3]);
        end
      end
      pe_q  <= pp_q;
      fle_q <= flp_q;
    end
  end

  // Stage X: cross products, wrapping at the component width
  logic                    vx_q;
  logic signed [CR_W-1:0]  cr_q [3][3];
  logic signed [OUT_W-1:0] px_q [3];
  sti_pkg::flags_t         flx_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          cr_q[k][i] <= CR_W'(m1_q[k][i]) - CR_W'(m2_q[k][i]);
        end
      end
      px_q  <= pe_q;
      flx_q <= fle_q;
    end
  end

  // Stage Q: partial products of the 32-bit halves of the six dot-product terms
  logic [CR_W-1:0] opa [6];
  logic [CR_W-1:0] opb [6];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      opa[j]   = cr_q[0][j];
      opb[j]   = cr_q[1][j];
      opa[j+3] = cr_q[1][j];
      opb[j+3] = cr_q[2][j];
    end
  end

  logic                    vq_q;
  logic signed [PP_W-1:0]  part_q [6][4];
  logic signed [OUT_W-1:0] pq_q [3];
  sti_pkg::flags_t         flq_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < 6; j++) begin
        part_q[j][0] <= PP_W'($signed(opa[j][CR_W-1:HW])) *
                        PP_W'($signed(opb[j][CR_W-1:HW]));
        part_q[j][1] <= PP_W'($signed(opa[j][CR_W-1:HW])) *
                        PP_W'($signed({1'b0, opb[j][HW-1:0]}));
        part_q[j][2] <= PP_W'($signed({1'b0, opa[j][HW-1:0]})) *
                        PP_W'($signed(opb[j][CR_W-1:HW]));
        part_q[j][3] <= PP_W'($signed({1'b0, opa[j][HW-1:0]})) *
                        PP_W'($signed({1'b0, opb[j][HW-1:0]}));
      end
      pq_q  <= px_q;
      flq_q <= flx_q;
    end
  end

  // Stage R: full 128-bit products
  logic                    vr_q;
  logic signed [DP_W-1:0]  prod_q [6];
  logic signed [OUT_W-1:0] pr_q [3];
  sti_pkg::flags_t         flr_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < 6; j++) begin
        prod_q[j] <= (DP_W'(part_q[j][0]) <<< (2 * HW)) +
                     (DP_W'(part_q[j][1]) <<< HW) +
                     (DP_W'(part_q[j][2]) <<< HW) +
                     DP_W'(part_q[j][3]);
      end
      pr_q  <= pq_q;
      flr_q <= flq_q;
    end
  end

  // Stage O: dot-product signs and final decision
  logic signed [DP_W-1:0] dot0, dot1;
  logic                   pos0, pos1, hit_d;

  always_comb begin
    dot0  = prod_q[0] + prod_q[1] + prod_q[2];
    dot1  = prod_q[3] + prod_q[4] + prod_q[5];
    pos0  = !dot0[DP_W-1] && (dot0 != '0);
    pos1  = !dot1[DP_W-1] && (dot1 != '0);
    hit_d = flr_q.par ? flr_q.inpl : (flr_q.go && pos0 && pos1);
  end

  logic                    vo_q;
  logic                    hito_q;
  logic signed [OUT_W-1:0] po_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hito_q <= hit_d;
      for (int i = 0; i < 3; i++) begin
        po_q[i] <= hit_d ? pr_q[i] : '0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Valid bits
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      vd_q  <= '0;
      vc_q2 <= 1'b0;
      vp_q  <= 1'b0;
      ve_q  <= 1'b0;
      vx_q  <= 1'b0;
      vq_q  <= 1'b0;
      vr_q  <= 1'b0;
      vo_q  <= 1'b0;
    end else if (adv) begin
      v0_q  <= in_valid_i;
      v1_q  <= v0_q;
      v2_q  <= v1_q;
      vd_q  <= {vd_q[F-2:0], v2_q};
      vc_q2 <= vd_q[F-1];
      vp_q  <= vc_q2;
      ve_q  <= vp_q;
      vx_q  <= ve_q;
      vq_q  <= vx_q;
      vr_q  <= vq_q;
      vo_q  <= vr_q;
    end
  end

  // ---------------------------------------------------------------------
  // Output skid register
  // ---------------------------------------------------------------------
  logic                    hits_q;
  logic signed [OUT_W-1:0] ps_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_q <= 1'b0;
    end else if (skid_q) begin
      if (out_ready_i) begin
        skid_q <= 1'b0;
      end
    end else if (vo_q && !out_ready_i) begin
      skid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_q && vo_q && !out_ready_i) begin
      hits_q <= hito_q;
      ps_q   <= po_q;
    end
  end

  assign out_valid_o = skid_q || vo_q;
  assign hit_o       = skid_q ? hits_q  : hito_q;
  assign hit_x_o     = skid_q ? ps_q[0] : po_q[0];
  assign hit_y_o     = skid_q ? ps_q[1] : po_q[1];
  assign hit_z_o     = skid_q ? ps_q[2] : po_q[2];

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (hit_x_o == '0 && hit_y_o == '0 && hit_z_o == '0))
    else $error("miss result carries a nonzero point");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!skid_q && vo_q && !out_ready_i) |=> skid_q)
    else $error("stalled result not held in skid register");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_q |=> (vo_q == $past(vo_q) && v0_q == $past(v0_q) && vr_q == $past(vr_q)))
    else $error("pipeline moved while skid register was full");

  a_par_no_go: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vr_q |-> !(flr_q.par && flr_q.go))
    else $error("parallel case also marked for containment test");

endmodule

/* rtl/sti_div_step.sv */
// One registered restoring-division step: one quotient bit per stage.
module sti_div_step #(
  parameter int unsigned REM_W = 43,
  parameter int unsigned QUO_W = 20
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [REM_W-1:0] rem_i,
  input  logic [QUO_W-1:0] quo_i,
  input  logic [REM_W-1:0] den_i,
  output logic [REM_W-1:0] rem_o,
  output logic [QUO_W-1:0] quo_o,
  output logic [REM_W-1:0] den_o
);

  logic [REM_W:0]   rem2;
  logic             ge;
  logic [REM_W:0]   diff;
  logic [REM_W-1:0] rem_d;
  logic [QUO_W-1:0] quo_d;
  logic [REM_W-1:0] rem_q;
  logic [QUO_W-1:0] quo_q;
  logic [REM_W-1:0] den_q;

  always_comb begin
    rem2  = {rem_i, 1'b0};
    ge    = rem2 >= {1'b0, den_i};
    diff  = rem2 - {1'b0, den_i};
    rem_d = ge ? diff[REM_W-1:0] : rem2[REM_W-1:0];
    quo_d = {quo_i[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      den_q <= den_i;
    end
  end

  assign rem_o = rem_q;
  assign quo_o = quo_q;
  assign den_o = den_q;

endmodule
